@@ rtl/plt_pkg.sv @@
`timescale 1ns / 1ps

package plt_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int ACTION_W  = 2;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int CNT_W     = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

endpackage

@@ rtl/packed_list_table.sv @@
`timescale 1ns / 1ps
// A no-op, or a remove or search on an empty list, goes straight to the result; an insert
// appends at the count; else entries are read and compared in turn from the first, and a
// remove that hits then moves each later entry one place down.
// Throughput: one item at a time, the next taken back in idle after the result is presented,
// set by the single read port of the entry memory and the one shared equality compare.
// Reset (aresetn low, synchronous) empties the list; entry storage is not cleared.
module packed_list_table
    #(
    parameter int DEPTH = plt_pkg::DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [plt_pkg::ACTION_W-1:0]        s_action,
    input  logic signed [plt_pkg::VALUE_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [plt_pkg::STATUS_W-1:0]        m_status,
    output logic [plt_pkg::POS_W-1:0]           m_position,
    output logic [plt_pkg::CNT_W-1:0]           m_count
);

    import plt_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Sequencer states: scan issues a read and then compares; shift issues a
    // read of the next entry and then writes it one place down.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESP
    } state_t;

    state_t               state_reg;
    action_t              action_reg;
    logic [VALUE_W-1:0]   key_reg;
    logic [CW-1:0]        used_reg;
    logic [IW-1:0]        scan_idx_reg;    // entry under compare
    logic [IW-1:0]        move_idx_reg;    // destination of the current move
    logic [IW-1:0]        hit_idx_reg;
    status_t              res_status_reg;
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [POS_W-1:0]     m_position_reg;
    logic [CNT_W-1:0]     m_count_reg;

    // Entry memory ports
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic [IW-1:0]        ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;

    // Shared compare unit and index arithmetic
    logic                 key_match;
    logic [CW-1:0]        scan_next;
    logic [CW-1:0]        move_next;
    logic [CW-1:0]        move_next2;
    logic [31:0]          hit_wide;
    logic [31:0]          used_wide;

    assign key_match  = (ram_rdata == key_reg);
    assign scan_next  = CW'(scan_idx_reg) + CW'(1);
    assign move_next  = CW'(move_idx_reg) + CW'(1);
    assign move_next2 = CW'(move_idx_reg) + CW'(2);

    assign hit_wide      = 32'(hit_idx_reg);
    assign used_wide     = 32'(used_reg);

    // Memory port steering: append writes at the count, shift writes the
    // entry read last cycle one place down.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = move_idx_reg;
        ram_wdata = ram_rdata;
        ram_raddr = scan_idx_reg;
        unique case (state_reg)
            S_INSERT: begin
                ram_we    = (used_reg < DEPTH_C);
                ram_waddr = used_reg[IW-1:0];
                ram_wdata = key_reg;
            end
            S_SHIFT_RD: begin
                ram_raddr = move_next[IW-1:0];
            end
            S_SHIFT_WR: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    plt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop the held result once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        action_reg     <= action_t'(s_action);
                        key_reg        <= s_value;
                        scan_idx_reg   <= '0;
                        hit_idx_reg    <= '0;
                        res_status_reg <= ST_OK;
                        case (action_t'(s_action))
                            ACT_INSERT: state_reg <= S_INSERT;
                            ACT_REMOVE, ACT_SEARCH: begin
                                if (used_reg == '0) begin
                                    res_status_reg <= ST_NOTFOUND;
                                    state_reg      <= S_RESP;
                                end else begin
                                    state_reg <= S_SCAN_RD;
                                end
                            end
                            default: state_reg <= S_RESP;
                        endcase
                    end
                end
                S_INSERT: begin
                    // Append at the count, or flag full and leave the list alone
                    if (used_reg < DEPTH_C) begin
                        used_reg <= used_reg + CW'(1);
                    end else begin
                        res_status_reg <= ST_FULL;
                    end
                    state_reg <= S_RESP;
                end
                S_SCAN_RD: begin
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (key_match) begin
                        hit_idx_reg  <= scan_idx_reg;
                        move_idx_reg <= scan_idx_reg;
                        if (action_reg == ACT_REMOVE) begin
                            if (scan_next < used_reg) begin
                                state_reg <= S_SHIFT_RD;
                            end else begin
                                used_reg  <= used_reg - CW'(1);
                                state_reg <= S_RESP;
                            end
                        end else begin
                            state_reg <= S_RESP;
                        end
                    end else if (scan_next < used_reg) begin
                        scan_idx_reg <= scan_next[IW-1:0];
                        state_reg    <= S_SCAN_RD;
                    end else begin
                        res_status_reg <= ST_NOTFOUND;
                        state_reg      <= S_RESP;
                    end
                end
                S_SHIFT_RD: begin
                    state_reg <= S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    // Advance the gap; stop once the last entry has moved down
                    if (move_next2 < used_reg) begin
                        move_idx_reg <= move_next[IW-1:0];
                        state_reg    <= S_SHIFT_RD;
                    end else begin
                        used_reg  <= used_reg - CW'(1);
                        state_reg <= S_RESP;
                    end
                end
                S_RESP: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_status_reg   <= res_status_reg;
                        m_position_reg <= (res_status_reg == ST_OK &&
                                           (action_reg == ACT_REMOVE ||
                                            action_reg == ACT_SEARCH))
                                          ? hit_wide[POS_W-1:0] : '0;
                        m_count_reg    <= used_wide[CNT_W-1:0];
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_position = m_position_reg;
    assign m_count    = m_count_reg;

endmodule

@@ rtl/plt_ram.sv @@
`timescale 1ns / 1ps

module plt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
